// ===== hw/rtl/jte_pkg.sv =====
package jte_pkg;

    localparam int TABLE_SLOTS_DEF = 16;

    localparam int FUNC_W = 3;
    localparam int PID_W  = 22;
    localparam int JIDF_W = 5;
    localparam int ST_W   = 2;
    localparam int SLOTF_W = 4;
    localparam int JID_STORE_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEL    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_BY_PID = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_BY_JID = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FG     = 3'd4;

    localparam logic [ST_W-1:0] RUN_FG = 2'd1;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PID_W-1:0]  proc_id;
        logic [JIDF_W-1:0] job_id_in;
        logic [ST_W-1:0]   run_state_in;
    } req_t;

    typedef struct packed {
        logic               ok;
        logic [PID_W-1:0]   found_pid;
        logic [JIDF_W-1:0]  found_jid;
        logic [ST_W-1:0]    found_state;
        logic [SLOTF_W-1:0] slot_index;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MAX,
        S_RESP
    } state_t;

endpackage

// ===== hw/rtl/jte_table.sv =====
module jte_table #(
    parameter int TABLE_SLOTS = jte_pkg::TABLE_SLOTS_DEF,
    parameter int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
    parameter int DATA_W = jte_pkg::PID_W + jte_pkg::JID_STORE_W + jte_pkg::ST_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [SLOT_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0]      mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [DATA_W-1:0]      rd_data_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ===== hw/rtl/jte_ctrl.sv =====
module jte_ctrl #(
    parameter int TABLE_SLOTS = jte_pkg::TABLE_SLOTS_DEF,
    parameter int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
    parameter int JID_W  = jte_pkg::JID_STORE_W,
    parameter int DATA_W = jte_pkg::PID_W + JID_W + jte_pkg::ST_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  jte_pkg::req_t     req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output jte_pkg::rsp_t     rsp,
    output logic              rd_en,
    output logic [SLOT_W-1:0] rd_addr,
    input  logic [DATA_W-1:0] rd_data,
    output logic              wr_en,
    output logic [SLOT_W-1:0] wr_addr,
    output logic [DATA_W-1:0] wr_data
);

    localparam int PID_W = jte_pkg::PID_W;
    localparam int ST_W  = jte_pkg::ST_W;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int JC_W  = (JID_W > jte_pkg::JIDF_W) ? JID_W : jte_pkg::JIDF_W;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_SLOTS);
    localparam logic [JID_W-1:0] LAST_JID = JID_W'(TABLE_SLOTS);

    jte_pkg::state_t state_reg, state_next;
    jte_pkg::req_t   req_reg, req_next;
    jte_pkg::rsp_t   rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] pidx_reg, pidx_next;
    logic              hit_reg, hit_next;
    logic [SLOT_W-1:0] hit_slot_reg, hit_slot_next;
    logic [PID_W-1:0]  hit_pid_reg, hit_pid_next;
    logic [JID_W-1:0]  hit_jid_reg, hit_jid_next;
    logic [ST_W-1:0]   hit_st_reg, hit_st_next;
    logic [JID_W-1:0]  next_jid_reg, next_jid_next;
    logic [JID_W-1:0]  max_reg, max_next;

    logic [PID_W-1:0] e_pid;
    logic [JID_W-1:0] e_jid;
    logic [ST_W-1:0]  e_st;
    logic             match;
    logic             refused;
    logic             issue;
    logic             accept;
    logic             rsp_free;
    logic [JID_W-1:0] max_upd;

    assign e_pid = rd_data[DATA_W-1 -: PID_W];
    assign e_jid = rd_data[ST_W +: JID_W];
    assign e_st  = rd_data[ST_W-1:0];

    assign accept   = req_valid && req_ready;
    assign issue    = (cnt_reg < LAST_CNT);
    assign rsp_free = !rsp_valid_reg || rsp_ready;
    assign max_upd  = (e_jid > max_reg) ? e_jid : max_reg;

    always_comb
    begin
        unique case (req_reg.func)
            jte_pkg::FUNC_ADD:    match = (e_pid == '0);
            jte_pkg::FUNC_DEL:    match = (e_pid == req_reg.proc_id);
            jte_pkg::FUNC_BY_PID: match = (e_pid == req_reg.proc_id);
            jte_pkg::FUNC_BY_JID: match = (JC_W'(e_jid) == JC_W'(req_reg.job_id_in));
            jte_pkg::FUNC_FG:     match = (e_st == jte_pkg::RUN_FG);
            default:              match = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (req.func)
            jte_pkg::FUNC_ADD,
            jte_pkg::FUNC_DEL,
            jte_pkg::FUNC_BY_PID: refused = (req.proc_id == '0);
            jte_pkg::FUNC_BY_JID: refused = (req.job_id_in == '0);
            jte_pkg::FUNC_FG:     refused = 1'b0;
            default:              refused = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jte_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = refused ? jte_pkg::S_RESP : jte_pkg::S_SCAN;
                end
            end
            jte_pkg::S_SCAN:
            begin
                if (pend_reg && match)
                begin
                    state_next = (req_reg.func == jte_pkg::FUNC_DEL) ? jte_pkg::S_MAX
                                                                    : jte_pkg::S_RESP;
                end
                else if (pend_reg && !issue)
                begin
                    state_next = jte_pkg::S_RESP;
                end
            end
            jte_pkg::S_MAX:
            begin
                if (pend_reg && !issue)
                begin
                    state_next = jte_pkg::S_RESP;
                end
            end
            jte_pkg::S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = jte_pkg::S_IDLE;
                end
            end
            default: state_next = jte_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready      = (state_reg == jte_pkg::S_IDLE);
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        hit_next       = hit_reg;
        hit_slot_next  = hit_slot_reg;
        hit_pid_next   = hit_pid_reg;
        hit_jid_next   = hit_jid_reg;
        hit_st_next    = hit_st_reg;
        next_jid_next  = next_jid_reg;
        max_next       = max_reg;
        rd_en          = 1'b0;
        rd_addr        = cnt_reg[SLOT_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = pidx_reg;
        wr_data        = '0;
        unique case (state_reg)
            jte_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    req_next = req;
                    cnt_next = '0;
                    hit_next = 1'b0;
                end
            end
            jte_pkg::S_SCAN:
            begin
                if (pend_reg && match)
                begin
                    hit_next      = 1'b1;
                    hit_slot_next = pidx_reg;
                    wr_en         = 1'b1;
                    cnt_next      = '0;
                    max_next      = '0;
                    if (req_reg.func == jte_pkg::FUNC_ADD)
                    begin
                        wr_data       = {req_reg.proc_id, next_jid_reg, req_reg.run_state_in};
                        hit_pid_next  = req_reg.proc_id;
                        hit_jid_next  = next_jid_reg;
                        hit_st_next   = req_reg.run_state_in;
                        next_jid_next = (next_jid_reg >= LAST_JID) ? JID_W'(1)
                                                                   : next_jid_reg + JID_W'(1);
                    end
                    else
                    begin
                        wr_en        = (req_reg.func == jte_pkg::FUNC_DEL);
                        hit_pid_next = e_pid;
                        hit_jid_next = e_jid;
                        hit_st_next  = e_st;
                    end
                end
                else if (issue)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = cnt_reg[SLOT_W-1:0];
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            jte_pkg::S_MAX:
            begin
                if (pend_reg)
                begin
                    max_next = max_upd;
                end
                if (issue)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
                else if (pend_reg)
                begin
                    next_jid_next = max_upd + JID_W'(1);
                end
            end
            jte_pkg::S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.ok          = hit_reg;
                    rsp_next.found_pid   = hit_reg ? hit_pid_reg : '0;
                    rsp_next.found_jid   = hit_reg ? jte_pkg::JIDF_W'(hit_jid_reg) : '0;
                    rsp_next.found_state = hit_reg ? hit_st_reg : '0;
                    rsp_next.slot_index  = hit_reg ? jte_pkg::SLOTF_W'(hit_slot_reg) : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jte_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            next_jid_reg  <= JID_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            next_jid_reg  <= next_jid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        rsp_reg      <= rsp_next;
        pidx_reg     <= pidx_next;
        hit_slot_reg <= hit_slot_next;
        hit_pid_reg  <= hit_pid_next;
        hit_jid_reg  <= hit_jid_next;
        hit_st_reg   <= hit_st_next;
        max_reg      <= max_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hw/rtl/job_table_engine_core.sv =====
// Job table of TABLE_SLOTS entries (process id, job id, run state) held in one
// synchronous memory that is scanned one slot per cycle, lowest slot first. A
// request is taken only while no other is in work; a finished word waits in
// the output register while the next request is taken. A lookup, add or delete
// stops scanning at the first matching slot or after the last slot; a refused
// request goes straight to the result. A delete that hits adds a full second
// scan for the largest remaining job id. A stalled output adds its stall. The
// memory read is registered. Job ids are stored at 32 bits since deletes can
// push them past the table size; the result shows their low 5 bits. Reset
// clears the per-slot valid flags at once, so no clearing pass follows reset.
module job_table_engine_core #(
    parameter int TABLE_SLOTS = jte_pkg::TABLE_SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  jte_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output jte_pkg::rsp_t rsp
);

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int JID_W  = jte_pkg::JID_STORE_W;
    localparam int DATA_W = jte_pkg::PID_W + JID_W + jte_pkg::ST_W;

    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;

    jte_table #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W),
        .DATA_W      (DATA_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    jte_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W),
        .JID_W       (JID_W),
        .DATA_W      (DATA_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

endmodule

// ===== tb/sv/job_table_checker.sv =====
`timescale 1ns / 100ps

module job_table_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_ready,
    input  jte_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_ready,
    input  jte_pkg::rsp_t rsp,
    output int            mismatches,
    output int            pending
);

    localparam int SLOTS   = jte_pkg::TABLE_SLOTS_DEF;
    localparam int PID_W   = jte_pkg::PID_W;
    localparam int JID_W   = jte_pkg::JID_STORE_W;
    localparam int JIDF_W  = jte_pkg::JIDF_W;
    localparam int ST_W    = jte_pkg::ST_W;
    localparam int SLOTF_W = jte_pkg::SLOTF_W;

    logic [PID_W-1:0] shadow_pid   [SLOTS];
    logic [JID_W-1:0] shadow_jid   [SLOTS];
    logic [ST_W-1:0]  shadow_state [SLOTS];
    logic [JID_W-1:0] shadow_next_jid;

    jte_pkg::rsp_t job_rsp_q [$];
    jte_pkg::rsp_t want;

    initial mismatches = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, exp_val);
        mismatches++;
    endtask

    function automatic jte_pkg::rsp_t slot_word(input int i);
        jte_pkg::rsp_t o;
        o.ok          = 1'b1;
        o.found_pid   = shadow_pid[i];
        o.found_jid   = JIDF_W'(shadow_jid[i]);
        o.found_state = shadow_state[i];
        o.slot_index  = SLOTF_W'(i);
        return o;
    endfunction

    // Apply one request to the shadow table and return the word it produces.
    function automatic jte_pkg::rsp_t run_job_op(input jte_pkg::req_t r);
        jte_pkg::rsp_t o;
        int slot;
        logic [JID_W-1:0] top_jid;
        o = '0;
        slot = -1;
        case (r.func)
            jte_pkg::FUNC_ADD:
            begin
                if (r.proc_id != '0)
                begin
                    for (int i = 0; i < SLOTS && slot < 0; i++)
                        if (shadow_pid[i] == '0)
                            slot = i;
                    if (slot >= 0)
                    begin
                        shadow_pid[slot]   = r.proc_id;
                        shadow_state[slot] = r.run_state_in;
                        shadow_jid[slot]   = shadow_next_jid;
                        if (shadow_next_jid >= JID_W'(SLOTS))
                            shadow_next_jid = JID_W'(1);
                        else
                            shadow_next_jid = shadow_next_jid + JID_W'(1);
                        o = slot_word(slot);
                    end
                end
            end
            jte_pkg::FUNC_DEL:
            begin
                if (r.proc_id != '0)
                begin
                    for (int i = 0; i < SLOTS && slot < 0; i++)
                        if (shadow_pid[i] == r.proc_id)
                            slot = i;
                    if (slot >= 0)
                    begin
                        o = slot_word(slot);
                        shadow_pid[slot]   = '0;
                        shadow_jid[slot]   = '0;
                        shadow_state[slot] = '0;
                        top_jid = '0;
                        for (int i = 0; i < SLOTS; i++)
                            if (shadow_jid[i] > top_jid)
                                top_jid = shadow_jid[i];
                        shadow_next_jid = top_jid + JID_W'(1);
                    end
                end
            end
            jte_pkg::FUNC_BY_PID:
            begin
                if (r.proc_id != '0)
                begin
                    for (int i = 0; i < SLOTS && slot < 0; i++)
                        if (shadow_pid[i] == r.proc_id)
                            slot = i;
                    if (slot >= 0)
                        o = slot_word(slot);
                end
            end
            jte_pkg::FUNC_BY_JID:
            begin
                if (r.job_id_in != '0)
                begin
                    for (int i = 0; i < SLOTS && slot < 0; i++)
                        if (shadow_jid[i] == JID_W'(r.job_id_in))
                            slot = i;
                    if (slot >= 0)
                        o = slot_word(slot);
                end
            end
            jte_pkg::FUNC_FG:
            begin
                for (int i = 0; i < SLOTS && slot < 0; i++)
                    if (shadow_state[i] == jte_pkg::RUN_FG)
                        slot = i;
                if (slot >= 0)
                    o = slot_word(slot);
            end
            default:
                o = '0;
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                shadow_pid[i]   = '0;
                shadow_jid[i]   = '0;
                shadow_state[i] = '0;
            end
            shadow_next_jid = JID_W'(1);
            job_rsp_q.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (job_rsp_q.size() == 0)
                    flag_mismatch("unexpected word", 32'(rsp.found_pid), 32'd0);
                else
                begin
                    want = job_rsp_q.pop_front();
                    if (rsp.ok !== want.ok)
                        flag_mismatch("ok", 32'(rsp.ok), 32'(want.ok));
                    if (rsp.found_pid !== want.found_pid)
                        flag_mismatch("found_pid", 32'(rsp.found_pid),
                                      32'(want.found_pid));
                    if (rsp.found_jid !== want.found_jid)
                        flag_mismatch("found_jid", 32'(rsp.found_jid),
                                      32'(want.found_jid));
                    if (rsp.found_state !== want.found_state)
                        flag_mismatch("found_state", 32'(rsp.found_state),
                                      32'(want.found_state));
                    if (rsp.slot_index !== want.slot_index)
                        flag_mismatch("slot_index", 32'(rsp.slot_index),
                                      32'(want.slot_index));
                end
            end
            if (req_valid && req_ready)
                job_rsp_q.push_back(run_job_op(req));
            pending <= job_rsp_q.size();
        end
    end

endmodule

// ===== tb/sv/job_table_engine_core_tb.sv =====
`timescale 1ns / 100ps

module job_table_engine_core_tb;

    localparam int FUNC_W = jte_pkg::FUNC_W;
    localparam int PID_W  = jte_pkg::PID_W;
    localparam int JIDF_W = jte_pkg::JIDF_W;
    localparam int ST_W   = jte_pkg::ST_W;
    localparam int SLOTS  = jte_pkg::TABLE_SLOTS_DEF;

    localparam int RANDOM_WORDS = 700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 16;

    localparam logic [ST_W-1:0] RUN_UNDEF = 2'd0;
    localparam logic [ST_W-1:0] RUN_BG    = 2'd2;
    localparam logic [ST_W-1:0] RUN_STOP  = 2'd3;

    localparam logic [PID_W-1:0] PID_MAX = '1;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_ready;
    jte_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_ready = 1'b0;
    jte_pkg::rsp_t rsp;

    logic gaps_on = 1'b1;
    int   mismatches;
    int   pending;
    int   cycles = 0;

    job_table_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    job_table_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n)
            rsp_ready <= !(gaps_on && $urandom_range(0, 99) < 18);

    function automatic jte_pkg::req_t make_req(input logic [FUNC_W-1:0] f,
                                               input logic [PID_W-1:0] pid,
                                               input logic [JIDF_W-1:0] jid,
                                               input logic [ST_W-1:0] st);
        jte_pkg::req_t r;
        r.func         = f;
        r.proc_id      = pid;
        r.job_id_in    = jid;
        r.run_state_in = st;
        return r;
    endfunction

    // Small pid pool so deletes and lookups hit; some zero and full-width pids.
    function automatic jte_pkg::req_t random_request(input int add_w);
        jte_pkg::req_t r;
        int   pick;
        int   del_w;
        del_w = 65 - add_w;
        pick = $urandom_range(0, 99);
        if (pick < add_w)
            r.func = jte_pkg::FUNC_ADD;
        else if (pick < add_w + del_w)
            r.func = jte_pkg::FUNC_DEL;
        else if (pick < add_w + del_w + 12)
            r.func = jte_pkg::FUNC_BY_PID;
        else if (pick < add_w + del_w + 24)
            r.func = jte_pkg::FUNC_BY_JID;
        else if (pick < add_w + del_w + 31)
            r.func = jte_pkg::FUNC_FG;
        else
            r.func = jte_pkg::FUNC_FG + FUNC_W'($urandom_range(1, 3));
        pick = $urandom_range(0, 99);
        if (pick < 5)
            r.proc_id = '0;
        else if (pick < 13)
            r.proc_id = PID_W'($urandom());
        else
            r.proc_id = PID_W'($urandom_range(1, 20));
        if ($urandom_range(0, 9) == 0)
            r.job_id_in = '0;
        else
            r.job_id_in = JIDF_W'($urandom_range(1, SLOTS + 1));
        r.run_state_in = ST_W'($urandom_range(0, 3));
        return r;
    endfunction

    task automatic push_request(input jte_pkg::req_t w);
        while (gaps_on && $urandom_range(0, 99) < 18)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_request(make_req(jte_pkg::FUNC_ADD, '0, 5'd1, jte_pkg::RUN_FG));
        push_request(make_req(jte_pkg::FUNC_DEL, 22'd5, '0, RUN_UNDEF));
        push_request(make_req(jte_pkg::FUNC_FG, '0, '0, RUN_UNDEF));
        push_request(make_req(jte_pkg::FUNC_BY_JID, 22'd1, '0, RUN_UNDEF));
        push_request(make_req(jte_pkg::FUNC_FG + 3'd1, 22'd3, 5'd3, jte_pkg::RUN_FG));
        push_request(make_req(jte_pkg::FUNC_FG + 3'd3, PID_MAX, 5'd17, RUN_STOP));
        for (int i = 0; i < SLOTS; i++)
            push_request(make_req(jte_pkg::FUNC_ADD, (i == 0) ? PID_MAX : PID_W'(i), '0,
                                  ST_W'(i % 4)));
        push_request(make_req(jte_pkg::FUNC_ADD, 22'd99, '0, RUN_BG));
        push_request(make_req(jte_pkg::FUNC_DEL, PID_MAX, '0, RUN_UNDEF));
        push_request(make_req(jte_pkg::FUNC_ADD, 22'd7, '0, jte_pkg::RUN_FG));
        push_request(make_req(jte_pkg::FUNC_BY_PID, 22'd7, '0, RUN_UNDEF));
        push_request(make_req(jte_pkg::FUNC_BY_JID, '0, 5'd17, RUN_UNDEF));
        push_request(make_req(jte_pkg::FUNC_FG, '0, '0, RUN_UNDEF));
        push_request(make_req(jte_pkg::FUNC_BY_PID, '0, 5'd2, RUN_UNDEF));

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            gaps_on = !(n >= 250 && n < 400);
            push_request(random_request(((n / 40) % 2) ? 50 : 18));
        end
        req_valid <= 1'b0;
        gaps_on = 1'b1;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
